// ===== rtl/cikl_pkg.sv =====
// Shared constants, tables and types for the coincidence-index key length core.
package cikl_pkg;

  localparam int unsigned LETTERS      = 26;
  localparam int unsigned LIDX_W       = 5;
  localparam int unsigned THR_CNT      = 6;
  localparam int unsigned THR_IDX_W    = 3;
  localparam logic [7:0]  FIRST_LETTER = 8'd65;
  localparam logic [7:0]  LAST_LETTER  = 8'd90;
  localparam logic [3:0]  LEN_UNKNOWN  = 4'd11;
  localparam logic [9:0]  IC_SCALE     = 10'd1000;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DRAIN = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_CMP   = 5'b10000
  } cikl_state_t;

  // Coincidence thresholds in thousandths, strongest first.
  function automatic logic [6:0] thr_coef(input logic [THR_IDX_W-1:0] idx);
    logic [6:0] val;
    case (idx)
      3'd0:    val = 7'd66;
      3'd1:    val = 7'd52;
      3'd2:    val = 7'd47;
      3'd3:    val = 7'd45;
      3'd4:    val = 7'd44;
      3'd5:    val = 7'd41;
      default: val = 7'd0;
    endcase
    return val;
  endfunction

  function automatic logic [3:0] thr_key_len(input logic [THR_IDX_W-1:0] idx);
    logic [3:0] val;
    case (idx)
      3'd0:    val = 4'd1;
      3'd1:    val = 4'd2;
      3'd2:    val = 4'd3;
      3'd3:    val = 4'd4;
      3'd4:    val = 4'd5;
      3'd5:    val = 4'd10;
      default: val = LEN_UNKNOWN;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/cikl_if.sv =====
// Valid/ready channel interfaces for ciphertext input and key length results.
interface cikl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

interface cikl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] estimated_key_length;

  modport source (output valid, output estimated_key_length, input ready);
  modport sink (input valid, input estimated_key_length, output ready);
endinterface

// ===== rtl/coincidence_index_key_length_core.sv =====
// Key length estimator from the index of coincidence over a letter-count memory.
//
//   channel   dir  fields                         beat when
//   in_chan   in   char_code[7:0], last           valid && ready
//   out_chan  out  estimated_key_length[3:0]      valid && ready
//
// One character per cycle while idle; letter counts live in a 26-entry memory,
// updated by read-modify-write with forwarding between back-to-back hits on one letter.
// After a last-flagged beat the core is busy and takes no input: a drain state,
// a walk of the memory (sum of c*(c-1), entries cleared as they pass), a pipeline
// flush, and the threshold compares in turn, strongest first.
// Reset is synchronous: counts read as zero through per-entry valid bits.
// A result waiting in the output register holds every compare step until it is taken.
module coincidence_index_key_length_core
  import cikl_pkg::*;
#(
  parameter int unsigned MAX_TEXT = 65535
) (
  input  logic           clk,
  input  logic           rst_n,
  cikl_in_if.sink        in_chan,
  cikl_out_if.source     out_chan
);

  localparam int unsigned CW   = $clog2(MAX_TEXT + 1);
  localparam int unsigned SW   = 2 * CW;
  localparam int unsigned CMPW = 2 * CW + 10;

  cikl_state_t state_r, state_nxt;

  logic [CW-1:0]   cnt_mem [LETTERS];
  logic [LETTERS-1:0] ent_vld_r, ent_vld_nxt;

  logic [CW-1:0]   len_r, len_nxt;
  logic [CW-1:0]   rdata_r;
  logic            rvld_r;
  logic [LIDX_W-1:0] rd_addr;

  logic            s1_vld_r;
  logic [LIDX_W-1:0] s1_idx_r;
  logic            fwd_hit_r;
  logic [CW-1:0]   fwd_data_r;
  logic [CW-1:0]   cur_cnt;
  logic [CW-1:0]   wr_data;

  logic [LIDX_W-1:0] walk_k_r;
  logic            w1_vld_r;
  logic [LIDX_W-1:0] w1_addr_r;
  logic [SW-1:0]   prod_r;
  logic            prod_vld_r;
  logic [SW-1:0]   sum_r;
  logic [SW-1:0]   pairs_r;
  logic [THR_IDX_W-1:0] thr_idx_r;
  logic [CW-1:0]   walk_cnt;

  logic [3:0]      out_len_r;
  logic            out_vld_r;

  logic            in_beat;
  logic            is_letter;
  logic            counted;
  logic [LIDX_W-1:0] in_idx;
  logic            load_ok;
  logic            cmp_pass;
  logic [CMPW-1:0] lhs, rhs;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign is_letter     = (in_chan.char_code >= FIRST_LETTER) &&
                         (in_chan.char_code <= LAST_LETTER);
  assign in_idx        = LIDX_W'(in_chan.char_code - FIRST_LETTER);
  assign counted       = len_r < CW'(MAX_TEXT);

  assign out_chan.valid                = out_vld_r;
  assign out_chan.estimated_key_length = out_len_r;

  assign rd_addr  = (state_r == ST_WALK) ? walk_k_r : in_idx;
  assign cur_cnt  = fwd_hit_r ? fwd_data_r : (rvld_r ? rdata_r : '0);
  assign wr_data  = cur_cnt + CW'(1);
  assign walk_cnt = rvld_r ? rdata_r : '0;

  assign lhs      = CMPW'(sum_r) * CMPW'(IC_SCALE);
  assign rhs      = CMPW'(pairs_r) * CMPW'(thr_coef(thr_idx_r));
  assign cmp_pass = lhs >= rhs;
  assign load_ok  = !out_vld_r || out_chan.ready;

  // Count memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    rdata_r <= cnt_mem[rd_addr];
    if (s1_vld_r) begin
      cnt_mem[s1_idx_r] <= wr_data;
    end
  end

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (s1_vld_r) begin
      ent_vld_nxt[s1_idx_r] = 1'b1;
    end
    if (w1_vld_r) begin
      ent_vld_nxt[w1_addr_r] = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (counted) begin
            len_nxt = len_r + CW'(1);
          end
          if (in_chan.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_k_r == LIDX_W'(LETTERS - 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!w1_vld_r && !prod_vld_r) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (load_ok && ((len_r < CW'(2)) || cmp_pass ||
                        (thr_idx_r == THR_IDX_W'(THR_CNT - 1)))) begin
          state_nxt = ST_IDLE;
          len_nxt   = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      ent_vld_r  <= '0;
      rvld_r     <= 1'b0;
      s1_vld_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
      w1_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      walk_k_r   <= '0;
      thr_idx_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      ent_vld_r <= ent_vld_nxt;
      rvld_r    <= ent_vld_r[rd_addr];

      s1_vld_r  <= in_beat && counted && is_letter;
      // Hit when the entry being read is written back at this same edge.
      fwd_hit_r <= in_beat && counted && is_letter && s1_vld_r && (s1_idx_r == in_idx);

      w1_vld_r   <= (state_r == ST_WALK);
      prod_vld_r <= w1_vld_r;

      if (state_r == ST_WALK) begin
        walk_k_r <= walk_k_r + LIDX_W'(1);
      end else begin
        walk_k_r <= '0;
      end

      if (state_r == ST_CMP) begin
        if (load_ok && !cmp_pass && (len_r >= CW'(2))) begin
          thr_idx_r <= thr_idx_r + THR_IDX_W'(1);
        end
      end else begin
        thr_idx_r <= '0;
      end

      if (out_vld_r && out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if ((state_r == ST_CMP) && (state_nxt == ST_IDLE)) begin
        out_vld_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_idx_r   <= in_idx;
    fwd_data_r <= wr_data;
    w1_addr_r  <= walk_k_r;
    prod_r     <= SW'(walk_cnt) * SW'(walk_cnt - CW'(1));
    if (state_r == ST_DRAIN) begin
      sum_r   <= '0;
      pairs_r <= SW'(len_r) * SW'(len_r - CW'(1));
    end else if (prod_vld_r) begin
      sum_r <= sum_r + prod_r;
    end
    if ((state_r == ST_CMP) && (state_nxt == ST_IDLE)) begin
      if (len_r < CW'(2)) begin
        out_len_r <= LEN_UNKNOWN;
      end else if (cmp_pass) begin
        out_len_r <= thr_key_len(thr_idx_r);
      end else begin
        out_len_r <= LEN_UNKNOWN;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the coincidence-index key length core with a built-in key length predictor.
module tb_top
  import cikl_pkg::*;
();

  localparam int unsigned MAX_TEXT    = 65535;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned REPORT_MAX  = 10;

  localparam longint unsigned IC_FLOOR [THR_CNT] = '{66, 52, 47, 45, 44, 41};
  localparam logic [3:0]      KEY_LEN  [THR_CNT] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd10};

  class key_length_board;
    bit [15:0]   letter_tally [LETTERS];
    int unsigned char_total;
    logic [3:0]  length_queue [$];
    int          mismatch_count;

    // Coincidence sum against the pair count, strongest threshold wins.
    function logic [3:0] estimate_length();
      longint unsigned coinc;
      longint unsigned pairs;
      longint unsigned n;
      longint unsigned c;
      logic [3:0]      answer;
      answer = LEN_UNKNOWN;
      n = char_total;
      if (n >= 2) begin
        coinc = 0;
        foreach (letter_tally[i]) begin
          c = letter_tally[i];
          if (c != 0) coinc += c * (c - 1);
        end
        pairs = n * (n - 1);
        for (int k = THR_CNT - 1; k >= 0; k--) begin
          if (coinc * 1000 >= IC_FLOOR[k] * pairs) answer = KEY_LEN[k];
        end
      end
      return answer;
    endfunction

    function void note_beat(logic [7:0] code, logic last_flag);
      // Stop counting once the text length saturates.
      if (char_total < MAX_TEXT) begin
        char_total++;
        if (code >= FIRST_LETTER && code <= LAST_LETTER)
          letter_tally[code - FIRST_LETTER]++;
      end
      if (last_flag) begin
        length_queue.push_back(estimate_length());
        foreach (letter_tally[i]) letter_tally[i] = '0;
        char_total = 0;
      end
    endfunction

    function void check_beat(logic [3:0] got);
      logic [3:0] want;
      if (length_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected key length beat: got %0d", got);
        return;
      end
      want = length_queue.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("key length mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cikl_in_if  in_chan ();
  cikl_out_if out_chan ();

  coincidence_index_key_length_core #(
    .MAX_TEXT (MAX_TEXT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  key_length_board board = new();

  int unsigned cycle_count;
  int unsigned chars_sent;
  int unsigned texts_sent;
  bit          src_idling;
  bit          sink_idling;
  bit          hold_request;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (rst_n !== 1'b1) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (sink_idling && $urandom_range(0, 99) < 15) begin
        out_chan.ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1)
        board.note_beat(in_chan.char_code, in_chan.last);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        board.check_beat(out_chan.estimated_key_length);
    end
  end

  task automatic send_char(logic [7:0] code, logic last_flag);
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= code;
    in_chan.last      <= last_flag;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    chars_sent++;
    if (last_flag) texts_sent++;
    if (src_idling && $urandom_range(0, 99) < 15) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Letters drawn from a window of the alphabet; a small window means a high index.
  task automatic send_text(int unsigned len, int unsigned alphabet, int unsigned noise_pct);
    int unsigned base;
    logic [7:0]  code;
    base = $urandom_range(0, LETTERS - 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        code = 8'($urandom_range(0, 255));
      else
        code = FIRST_LETTER + 8'((base + $urandom_range(0, alphabet - 1)) % LETTERS);
      send_char(code, i == len - 1);
    end
  endtask

  task automatic send_random_text();
    int unsigned pick;
    int unsigned len;
    int unsigned alphabet;
    pick = $urandom_range(0, 99);
    if (pick < 10)      len = $urandom_range(1, 2);
    else if (pick < 85) len = $urandom_range(2, 30);
    else                len = $urandom_range(40, 200);
    if ($urandom_range(0, 99) < 30) alphabet = $urandom_range(1, LETTERS);
    else                            alphabet = $urandom_range(14, LETTERS);
    send_text(len, alphabet, $urandom_range(0, 3) * 10);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.char_code = 8'd0;
    in_chan.last      = 1'b0;
    src_idling        = 1'b1;
    sink_idling       = 1'b1;
    hold_request      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Single character: too short to estimate.
    send_char(FIRST_LETTER, 1'b1);
    send_char(LAST_LETTER, 1'b0);
    send_char(LAST_LETTER, 1'b1);
    // Non-letters only: no coincidences; then texts mixing letters and non-letters.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(FIRST_LETTER - 8'd1, 1'b0);
    send_char(LAST_LETTER + 8'd1, 1'b0);
    send_char(FIRST_LETTER, 1'b0);
    send_char(LAST_LETTER, 1'b0);
    send_char(FIRST_LETTER, 1'b1);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b1);
    // All distinct letters: index below every threshold.
    for (int i = 0; i < 10; i++) send_char(FIRST_LETTER + 8'(i), i == 9);

    while (chars_sent < 1050 || texts_sent < 45) begin
      src_idling  = $urandom_range(0, 99) < 70;
      sink_idling = $urandom_range(0, 99) < 70;
      send_random_text();
    end

    // Hold the receiver off while short texts keep coming in.
    src_idling   = 1'b0;
    sink_idling  = 1'b0;
    hold_request = 1'b1;
    repeat (8) send_text($urandom_range(2, 8), $urandom_range(1, LETTERS), 10);

    // Long run of one letter: highest index.
    send_text(100, 1, 0);
    send_text(4, 2, 0);

    repeat (8) send_random_text();
    in_chan.valid <= 1'b0;

    while (board.length_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cikl_pkg.sv
rtl/cikl_if.sv
rtl/coincidence_index_key_length_core.sv
tb/tb_top.sv
